/* rtl/igm_pkg.sv */
`default_nettype none

package igm_pkg;

   localparam int MAX_COLS_DEF = 1024;
   localparam int MAX_ROWS_DEF = 1024;

   localparam int PIX_W     = 8;
   localparam int GRAD_W    = 9;
   localparam int POS_W     = 10;
   localparam int CFG_W     = 11;
   localparam int CSR_IDX_W = 2;

   localparam logic [CFG_W-1:0] FRAME_SIZE_RESET = CFG_W'(2);

   localparam logic signed [GRAD_W-1:0] RUN_MIN_INIT = GRAD_W'(255);
   localparam logic signed [GRAD_W-1:0] RUN_MAX_INIT = -GRAD_W'(255);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FRAME_ROWS = 2'd0,
      REG_FRAME_COLS = 2'd1
   } csr_reg_type;

   typedef struct packed {
      logic [PIX_W-1:0] up;
      logic [PIX_W-1:0] older;
   } line_word_type;

endpackage

`default_nettype wire

/* rtl/image_gradient_with_minmax.sv */
// Order: results of a row leave one row after it, but the last row's leave with it;
// a result waits in the mask and neighbourhood registers, then the output register.
// Throughput: one pixel per cycle while req_stall is low; on the last row a pixel
// past the first column releases two results (the final pixel three), which the
// single output register takes one at a time while req_stall holds the input.
// Reset: position counters clear, min/max tracking returns to +255/-255, frame
// size registers return to 2; the line store is not cleared and needs no sweep.
`default_nettype none

module image_gradient_with_minmax #(
   parameter int MAX_COLS = igm_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = igm_pkg::MAX_ROWS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,

   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [igm_pkg::PIX_W-1:0]            req_pixel,

   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [igm_pkg::POS_W-1:0]                 rsp_out_row,
   output logic [igm_pkg::POS_W-1:0]                 rsp_out_col,
   output logic signed [igm_pkg::GRAD_W-1:0]         rsp_grad_x,
   output logic signed [igm_pkg::GRAD_W-1:0]         rsp_grad_y,
   output logic                                      rsp_last_of_run,
   output logic                                      rsp_frame_done,
   output logic signed [igm_pkg::GRAD_W-1:0]         rsp_min_x,
   output logic signed [igm_pkg::GRAD_W-1:0]         rsp_max_x,
   output logic signed [igm_pkg::GRAD_W-1:0]         rsp_min_y,
   output logic signed [igm_pkg::GRAD_W-1:0]         rsp_max_y,

   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [igm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [igm_pkg::CFG_W-1:0]            csr_wdata
);

   localparam int CW  = (MAX_COLS > 2) ? $clog2(MAX_COLS) : 1;
   localparam int RW  = (MAX_ROWS > 2) ? $clog2(MAX_ROWS) : 1;
   localparam int CLW = ((CW > igm_pkg::CFG_W) ? CW : igm_pkg::CFG_W) + 1;
   localparam int RLW = ((RW > igm_pkg::CFG_W) ? RW : igm_pkg::CFG_W) + 1;
   localparam int PW  = igm_pkg::PIX_W;
   localparam int GW  = igm_pkg::GRAD_W;

   igm_pkg::line_word_type line_mem [MAX_COLS];

   logic [igm_pkg::CFG_W-1:0] frame_rows_ff, frame_cols_ff;
   logic [CLW-1:0]            cols_ext, cols_clamp;
   logic [RLW-1:0]            rows_ext, rows_clamp;
   logic [CW-1:0]             cols_m1;
   logic [RW-1:0]             rows_m1;

   logic [RW-1:0]             row_ff, row_in;
   logic [CW-1:0]             col_ff, col_in;

   igm_pkg::line_word_type    rd_ff, cur_ff;
   logic [CW-1:0]             rd_addr;

   logic [PW-1:0]             px_ff, up_left_ff, left1_ff, left2_ff;
   logic [RW-1:0]             s1_row_ff;
   logic [CW-1:0]             s1_col_ff;
   logic                      j_gt0_ff, j_ge2_ff, right_ok_ff, i_ge2_ff;
   logic [2:0]                mask_ff, mask_in, new_mask, sel, mask_left;

   logic                      acc, out_free, load, last_row, row_end;
   logic                      rsp_valid_ff, rsp_valid_in;

   logic signed [GW-1:0]      run_min_x_ff, run_max_x_ff, run_min_y_ff, run_max_y_ff;
   logic signed [GW-1:0]      run_min_x_in, run_max_x_in, run_min_y_in, run_max_y_in;
   logic signed [GW-1:0]      nmin_x, nmax_x, nmin_y, nmax_y;

   logic [PW-1:0]             a_l, a_r, a_u, b_l;
   logic signed [GW-1:0]      a_x, a_y, b_x, b_y, c_x, c_y, gx, gy;
   logic [RW-1:0]             res_row;
   logic [CW-1:0]             res_col;
   logic                      res_done, res_last;

   logic [igm_pkg::POS_W-1:0] out_row_ff, out_col_ff;
   logic signed [GW-1:0]      grad_x_ff, grad_y_ff;
   logic signed [GW-1:0]      min_x_ff, max_x_ff, min_y_ff, max_y_ff;
   logic                      last_ff, done_ff;

   logic                      csr_wr, csr_restart;

   // frame size, clamped to the supported range
   always_comb begin
      cols_ext = CLW'(frame_cols_ff);
      rows_ext = RLW'(frame_rows_ff);
      if (cols_ext < CLW'(2)) begin
         cols_clamp = CLW'(2);
      end else if (cols_ext > CLW'(MAX_COLS)) begin
         cols_clamp = CLW'(MAX_COLS);
      end else begin
         cols_clamp = cols_ext;
      end
      if (rows_ext < RLW'(2)) begin
         rows_clamp = RLW'(2);
      end else if (rows_ext > RLW'(MAX_ROWS)) begin
         rows_clamp = RLW'(MAX_ROWS);
      end else begin
         rows_clamp = rows_ext;
      end
      cols_m1 = CW'(cols_clamp - CLW'(1));
      rows_m1 = RW'(rows_clamp - RLW'(1));
   end

   assign csr_ready   = 1'b1;
   assign csr_wr      = csr_valid & csr_ready;
   assign csr_restart = csr_wr &
                        (csr_index inside {igm_pkg::REG_FRAME_ROWS, igm_pkg::REG_FRAME_COLS});

   // input side: position, result mask, next counters
   always_comb begin
      acc      = req_valid & ~req_stall;
      last_row = (row_ff == rows_m1);
      row_end  = (col_ff == cols_m1);
      new_mask[0] = (row_ff != RW'(0));
      new_mask[1] = last_row & (col_ff != CW'(0));
      new_mask[2] = last_row & row_end;
      rd_addr  = row_end ? CW'(0) : col_ff + CW'(1);
      row_in   = row_ff;
      col_in   = col_ff;
      if (row_end) begin
         col_in = CW'(0);
         row_in = last_row ? RW'(0) : row_ff + RW'(1);
      end else begin
         col_in = col_ff + CW'(1);
      end
   end

   // result selection and gradients
   always_comb begin
      out_free  = ~rsp_valid_ff | ~rsp_stall;
      load      = out_free & (mask_ff != 3'b000);
      sel       = mask_ff[0] ? 3'b001 : (mask_ff[1] ? 3'b010 : {mask_ff[2], 2'b00});
      mask_left = mask_ff & ~sel;
      req_stall = ~((mask_ff == 3'b000) | (load & (mask_left == 3'b000)));
      rsp_valid_in = load | (rsp_valid_ff & rsp_stall);
      mask_in   = acc ? new_mask : (load ? mask_left : mask_ff);

      a_l = j_gt0_ff ? up_left_ff : '0;
      a_r = right_ok_ff ? rd_ff.up : '0;
      a_u = i_ge2_ff ? cur_ff.older : '0;
      b_l = j_ge2_ff ? left2_ff : '0;
      a_x = $signed({1'b0, a_l}) - $signed({1'b0, a_r});
      a_y = $signed({1'b0, px_ff}) - $signed({1'b0, a_u});
      b_x = $signed({1'b0, b_l}) - $signed({1'b0, px_ff});
      b_y = $signed(GW'(0)) - $signed({1'b0, up_left_ff});
      c_x = $signed({1'b0, left1_ff});
      c_y = $signed(GW'(0)) - $signed({1'b0, cur_ff.up});

      res_last = (mask_left == 3'b000);
      res_done = 1'b0;
      if (sel[0]) begin
         gx = a_x;
         gy = a_y;
         res_row = s1_row_ff - RW'(1);
         res_col = s1_col_ff;
      end else if (sel[1]) begin
         gx = b_x;
         gy = b_y;
         res_row = s1_row_ff;
         res_col = s1_col_ff - CW'(1);
      end else begin
         gx = c_x;
         gy = c_y;
         res_row = s1_row_ff;
         res_col = s1_col_ff;
         res_done = 1'b1;
      end

      nmin_x = (gx < run_min_x_ff) ? gx : run_min_x_ff;
      nmax_x = (gx > run_max_x_ff) ? gx : run_max_x_ff;
      nmin_y = (gy < run_min_y_ff) ? gy : run_min_y_ff;
      nmax_y = (gy > run_max_y_ff) ? gy : run_max_y_ff;

      run_min_x_in = run_min_x_ff;
      run_max_x_in = run_max_x_ff;
      run_min_y_in = run_min_y_ff;
      run_max_y_in = run_max_y_ff;
      if (csr_restart || (load && res_done)) begin
         run_min_x_in = igm_pkg::RUN_MIN_INIT;
         run_max_x_in = igm_pkg::RUN_MAX_INIT;
         run_min_y_in = igm_pkg::RUN_MIN_INIT;
         run_max_y_in = igm_pkg::RUN_MAX_INIT;
      end else if (load) begin
         run_min_x_in = nmin_x;
         run_max_x_in = nmax_x;
         run_min_y_in = nmin_y;
         run_max_y_in = nmax_y;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_rows_ff <= igm_pkg::FRAME_SIZE_RESET;
         frame_cols_ff <= igm_pkg::FRAME_SIZE_RESET;
         row_ff        <= '0;
         col_ff        <= '0;
         mask_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         run_min_x_ff  <= igm_pkg::RUN_MIN_INIT;
         run_max_x_ff  <= igm_pkg::RUN_MAX_INIT;
         run_min_y_ff  <= igm_pkg::RUN_MIN_INIT;
         run_max_y_ff  <= igm_pkg::RUN_MAX_INIT;
      end else begin
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
         run_min_x_ff <= run_min_x_in;
         run_max_x_ff <= run_max_x_in;
         run_min_y_ff <= run_min_y_in;
         run_max_y_ff <= run_max_y_in;
         if (csr_restart) begin
            row_ff <= '0;
            col_ff <= '0;
            case (csr_index)
               igm_pkg::REG_FRAME_ROWS: frame_rows_ff <= csr_wdata;
               igm_pkg::REG_FRAME_COLS: frame_cols_ff <= csr_wdata;
               default: ;
            endcase
         end else if (acc) begin
            row_ff <= row_in;
            col_ff <= col_in;
         end
      end
   end

   // line store: one write and one look-ahead read per item
   always_ff @(posedge clock) begin
      if (acc) begin
         line_mem[col_ff] <= '{up: req_pixel, older: rd_ff.up};
         rd_ff            <= line_mem[rd_addr];
      end
   end

   // hold the accepted item and its neighborhood
   always_ff @(posedge clock) begin
      if (acc) begin
         cur_ff      <= rd_ff;
         up_left_ff  <= cur_ff.up;
         left2_ff    <= left1_ff;
         left1_ff    <= px_ff;
         px_ff       <= req_pixel;
         s1_row_ff   <= row_ff;
         s1_col_ff   <= col_ff;
         j_gt0_ff    <= (col_ff != CW'(0));
         j_ge2_ff    <= (col_ff > CW'(1));
         right_ok_ff <= ~row_end;
         i_ge2_ff    <= (row_ff > RW'(1));
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (load) begin
         out_row_ff <= igm_pkg::POS_W'(res_row);
         out_col_ff <= igm_pkg::POS_W'(res_col);
         grad_x_ff  <= gx;
         grad_y_ff  <= gy;
         last_ff    <= res_last;
         done_ff    <= res_done;
         min_x_ff   <= res_done ? nmin_x : '0;
         max_x_ff   <= res_done ? nmax_x : '0;
         min_y_ff   <= res_done ? nmin_y : '0;
         max_y_ff   <= res_done ? nmax_y : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_row     = out_row_ff;
   assign rsp_out_col     = out_col_ff;
   assign rsp_grad_x      = grad_x_ff;
   assign rsp_grad_y      = grad_y_ff;
   assign rsp_last_of_run = last_ff;
   assign rsp_frame_done  = done_ff;
   assign rsp_min_x       = min_x_ff;
   assign rsp_max_x       = max_x_ff;
   assign rsp_min_y       = min_y_ff;
   assign rsp_max_y       = max_y_ff;

endmodule

`default_nettype wire
